// File: sv/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// shared constants and types of the matrix multiply block
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_DATA_WIDTH = 16;
  localparam int CFG_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int PROD_W         = 34;
  localparam int IDX_W          = 3;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_OF_A  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_OF_B  = 2'd2
  } reg_idx_t;

  // effective dimensions, each 1..MAX_DIM
  typedef struct packed {
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] p;
  } dims_t;

endpackage

`default_nettype wire

// File: sv/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// dense product C = A x B of signed fixed-point matrices up to MAX_DIM square
//
//   channel   handshake              payload
//   input     start / busy           element_value
//   config    cfg_we                 cfg_index, cfg_data
//   result    result_strobe          product_value, out_row, out_col, last_flag
//
// an element transfers whenever start is high and busy is low; busy is also
// high while the queue is full; the last element of B starts the
// multiply-accumulate on one multiplier, and busy stays high from that
// transfer until the cycle after the final result is on the ports, so the
// next element can transfer only once busy is low again
// a result comes at the end of each dot product and cannot be stalled
// rst is synchronous; after reset all three dimensions are 8
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DATA_WIDTH-1:0]    element_value,
  output logic                          busy,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  output logic                          result_strobe,
  output logic signed [PROD_W-1:0]      product_value,
  output logic        [IDX_W-1:0]       out_row,
  output logic        [IDX_W-1:0]       out_col,
  output logic                          last_flag
);

  localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int ENT_W = 2 + AW + DATA_WIDTH;

  dims_t            dims;
  logic             push;
  logic [ENT_W-1:0] push_data;
  logic             pop;
  logic [ENT_W-1:0] pop_data;
  logic             q_full;
  logic             q_empty;
  logic             done;

  mm_front #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .element_value (element_value),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .dims          (dims),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full),
    .done          (done)
  );

  mm_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  mm_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dims          (dims),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .result_strobe (result_strobe),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_flag     (last_flag),
    .done          (done)
  );

endmodule

`default_nettype wire

// File: sv/mm_fifo.sv
// ----------------------------------------------------------------------------
// mm_fifo
// short queue between the load front end and the compute back end
// ----------------------------------------------------------------------------
`default_nettype none

module mm_fifo
  import mm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      count <= CW'(count + CW'(push && !full) - CW'(pop && !empty));
    end
  end

endmodule

`default_nettype wire

// File: sv/mm_front.sv
// ----------------------------------------------------------------------------
// mm_front
// config registers, load counting and sorting of elements into A and B
// ----------------------------------------------------------------------------
`default_nettype none

module mm_front
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int AW         = 6,
  parameter int ENT_W      = 2 + AW + DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] element_value,
  output logic                       busy,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output dims_t                      dims,
  output logic                       push,
  output logic      [ENT_W-1:0]      push_data,
  input  wire logic                  q_full,
  input  wire logic                  done
);

  localparam int LCW = (2 * MAX_DIM * MAX_DIM > 1) ? $clog2(2 * MAX_DIM * MAX_DIM) : 1;
  localparam int SW  = 2 * CFG_W + 1;

  logic [CFG_W-1:0] rows_of_a;
  logic [CFG_W-1:0] inner_size;
  logic [CFG_W-1:0] cols_of_b;
  logic [LCW-1:0]   load_count;
  logic             hold;

  logic [SW-1:0] a_len;
  logic [SW-1:0] total;
  logic [SW-1:0] e_ext;
  logic          is_b;
  logic          is_last;
  logic [AW-1:0] addr;
  logic          accept;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = CFG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    dims.m = eff_dim(rows_of_a);
    dims.n = eff_dim(inner_size);
    dims.p = eff_dim(cols_of_b);
  end

  assign a_len   = SW'(dims.m) * SW'(dims.n);
  assign total   = SW'(a_len + SW'(dims.n) * SW'(dims.p));
  assign e_ext   = SW'(load_count);
  assign is_b    = (e_ext >= a_len);
  assign is_last = (SW'(e_ext + 1'b1) == total);
  assign addr    = is_b ? AW'(e_ext - a_len) : AW'(e_ext);

  assign busy      = hold || q_full;
  assign accept    = start && !busy;
  assign push      = accept;
  assign push_data = {is_b, is_last, addr, element_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a  <= CFG_RESET;
      inner_size <= CFG_RESET;
      cols_of_b  <= CFG_RESET;
      load_count <= '0;
      hold       <= 1'b0;
    end else begin
      if (done) begin
        hold <= 1'b0;
      end
      if (accept) begin
        if (is_last) begin
          load_count <= '0;
          hold       <= 1'b1;
        end else begin
          load_count <= LCW'(load_count + 1'b1);
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_OF_A: begin
            rows_of_a  <= cfg_data;
            load_count <= '0;
          end
          REG_INNER_SIZE: begin
            inner_size <= cfg_data;
            load_count <= '0;
          end
          REG_COLS_OF_B: begin
            cols_of_b  <= cfg_data;
            load_count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/mm_back.sv
// ----------------------------------------------------------------------------
// mm_back
// element stores and the shared multiply-accumulate sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module mm_back
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int AW         = 6,
  parameter int ENT_W      = 2 + AW + DATA_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dims_t                    dims,
  input  wire logic                     q_empty,
  input  wire logic [ENT_W-1:0]         q_data,
  output logic                          pop,
  output logic                          result_strobe,
  output logic signed [PROD_W-1:0]      product_value,
  output logic        [IDX_W-1:0]       out_row,
  output logic        [IDX_W-1:0]       out_col,
  output logic                          last_flag,
  output logic                          done
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ACC_R  = 2 * DATA_WIDTH + $clog2(MAX_DIM) + 1;
  localparam int ACC_W  = (ACC_R > PROD_W + 1) ? ACC_R : PROD_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - PROD_W + 1){1'b0}}, {(PROD_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - PROD_W + 1){1'b1}}, {(PROD_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    S_LOAD = 2'b01,
    S_CALC = 2'b10
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             lastall;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic [DATA_WIDTH-1:0] a_mem [DEPTH];
  logic [DATA_WIDTH-1:0] b_mem [DEPTH];

  state_t state;
  state_t state_next;

  logic                  e_is_b;
  logic                  e_is_last;
  logic [AW-1:0]         e_addr;
  logic [DATA_WIDTH-1:0] e_data;

  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] c;
  logic [IDX_W-1:0] k;
  logic [AW-1:0]    a_base;
  logic [AW-1:0]    b_ptr;
  logic [AW-1:0]    a_addr;
  logic             k_end;
  logic             c_end;
  logic             r_end;
  logic             issue;
  tag_t             t0;

  logic [DATA_WIDTH-1:0]         a_q;
  logic [DATA_WIDTH-1:0]         b_q;
  tag_t                          t1;
  logic signed [2*DATA_WIDTH-1:0] prod;
  tag_t                          t2;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_next;
  logic signed [ACC_W-1:0]       prod_ext;

  assign {e_is_b, e_is_last, e_addr, e_data} = q_data;

  assign pop   = (state == S_LOAD) && !q_empty;
  assign issue = (state == S_CALC);

  assign k_end  = (CFG_W'(k) == CFG_W'(dims.n - 1'b1));
  assign c_end  = (CFG_W'(c) == CFG_W'(dims.p - 1'b1));
  assign r_end  = (CFG_W'(r) == CFG_W'(dims.m - 1'b1));
  assign a_addr = AW'(a_base + AW'(k));

  always_comb begin
    t0.valid   = issue;
    t0.first   = (k == '0);
    t0.lastk   = k_end;
    t0.lastall = k_end && c_end && r_end;
    t0.row     = r;
    t0.col     = c;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (pop && e_is_last) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (k_end && c_end && r_end) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (pop) begin
      if (e_is_b) begin
        b_mem[e_addr] <= e_data;
      end else begin
        a_mem[e_addr] <= e_data;
      end
    end
    a_q <= a_mem[a_addr];
    b_q <= b_mem[b_ptr];
  end

  // index walk over row, column and inner position
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      r      <= '0;
      c      <= '0;
      k      <= '0;
      a_base <= '0;
      b_ptr  <= '0;
    end else if (k_end) begin
      k <= '0;
      if (c_end) begin
        c      <= '0;
        b_ptr  <= '0;
        r      <= IDX_W'(r + 1'b1);
        a_base <= AW'(a_base + AW'(dims.n));
      end else begin
        c     <= IDX_W'(c + 1'b1);
        b_ptr <= AW'(IDX_W'(c + 1'b1));
      end
    end else begin
      k     <= IDX_W'(k + 1'b1);
      b_ptr <= AW'(b_ptr + AW'(dims.p));
    end
  end

  assign prod_ext = ACC_W'(prod);
  assign acc_next = t2.first ? prod_ext : ACC_W'(acc + prod_ext);

  always_ff @(posedge clk) begin
    prod <= $signed(a_q) * $signed(b_q);
    if (t2.valid) begin
      acc <= acc_next;
    end
    out_row   <= t2.row;
    out_col   <= t2.col;
    last_flag <= t2.lastall;
    if (acc_next > SAT_MAX) begin
      product_value <= SAT_MAX[PROD_W-1:0];
    end else if (acc_next < SAT_MIN) begin
      product_value <= SAT_MIN[PROD_W-1:0];
    end else begin
      product_value <= acc_next[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      t1            <= '0;
      t2            <= '0;
      result_strobe <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      t1            <= t0;
      t2            <= t1;
      result_strobe <= t2.valid && t2.lastk;
      done          <= t2.valid && t2.lastk && t2.lastall;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_matrix_multiply.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply
// self-checking bench for the matrix multiply block
//
// a queue of pending steps (element transfers, register writes and drains)
// is filled at time zero and played out by a driver on the falling edge
// a monitor on the rising edge keeps its own copy of the dimensions and the
// loaded matrices, predicts every product element on the last element of B
// and checks each result strobe field by field against the oldest prediction
// starts with saturation and out-of-range dimension cases, then random
// dimensions and data, partial loads cut short by a register write, and
// random gaps on the sender side
// ----------------------------------------------------------------------------

module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int ELEM_W         = DEF_DATA_WIDTH;
  localparam int STORE_DEPTH    = DEF_MAX_DIM * DEF_MAX_DIM;
  localparam int ITEM_TARGET    = 470;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 50;

  localparam longint PROD_MAX = (longint'(1) <<< (PROD_W - 1)) - 1;
  localparam longint PROD_MIN = -(longint'(1) <<< (PROD_W - 1));

  // index outside the register list, writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {STEP_ELEM, STEP_CFG, STEP_DRAIN} step_kind_t;
  typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_SMALL} fill_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [ELEM_W-1:0]      value;
  } step_t;

  typedef struct {
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
  } product_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 start         = 1'b0;
  logic [ELEM_W-1:0]    element_value = '0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 busy;
  logic                 result_strobe;
  logic signed [PROD_W-1:0] product_value;
  logic [IDX_W-1:0]     out_row;
  logic [IDX_W-1:0]     out_col;
  logic                 last_flag;

  matrix_multiply i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .element_value (element_value),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_flag     (last_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  step_t    pend_steps[$];
  product_t product_q[$];

  // predictor state
  logic [CFG_W-1:0]  model_dim [3];
  logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
  logic [ELEM_W-1:0] b_mem [STORE_DEPTH];
  int                load_cnt;

  // stimulus side copy of the raw dimensions
  logic [CFG_W-1:0]  stim_dim [3];
  int                stim_items;

  int       mismatch_count = 0;
  int       quiet_cycles   = 0;
  logic     elem_xfer      = 1'b0;
  product_t want;

  int                   gap_left    = 0;
  int                   gap_style   = 1;
  int                   settle_left = SETTLE_CYCLES;
  logic                 n_start;
  logic [ELEM_W-1:0]    n_value;
  logic                 n_we;
  logic [CFG_IDX_W-1:0] n_index;
  logic [CFG_W-1:0]     n_data;

  function automatic int eff_dim(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(raw);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want_val);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want_val);
    mismatch_count++;
  endtask

  // store one element; the last element of B yields the whole product
  task automatic accept_element(input logic [ELEM_W-1:0] value);
    int       m;
    int       n;
    int       p;
    int       a_len;
    longint   acc;
    product_t res;
    m     = eff_dim(model_dim[REG_ROWS_OF_A]);
    n     = eff_dim(model_dim[REG_INNER_SIZE]);
    p     = eff_dim(model_dim[REG_COLS_OF_B]);
    a_len = m * n;
    if (load_cnt < a_len) a_mem[load_cnt] = value;
    else b_mem[load_cnt - a_len] = value;
    if (load_cnt + 1 < a_len + n * p) begin
      load_cnt++;
    end else begin
      load_cnt = 0;
      for (int r = 0; r < m; r++) begin
        for (int c = 0; c < p; c++) begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'($signed(a_mem[r * n + k])) * longint'($signed(b_mem[k * p + c]));
          if (acc > PROD_MAX) acc = PROD_MAX;
          else if (acc < PROD_MIN) acc = PROD_MIN;
          res.product = acc[PROD_W-1:0];
          res.row     = IDX_W'(r);
          res.col     = IDX_W'(c);
          res.last    = (r == m - 1) && (c == p - 1);
          product_q.push_back(res);
        end
      end
    end
  endtask

  task automatic push_elem(input logic [ELEM_W-1:0] value);
    step_t st;
    st.kind  = STEP_ELEM;
    st.index = '0;
    st.value = value;
    pend_steps.push_back(st);
    stim_items++;
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    step_t st;
    st.kind  = STEP_CFG;
    st.index = index;
    st.value = ELEM_W'(value);
    pend_steps.push_back(st);
    if (index != REG_UNUSED) stim_dim[index] = value;
  endtask

  task automatic push_drain();
    step_t st;
    st.kind  = STEP_DRAIN;
    st.index = '0;
    st.value = '0;
    pend_steps.push_back(st);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem(input fill_t fill);
    case (fill)
      FILL_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          4: return 16'h0001;
          default: return 16'h0100;
        endcase
      end
      FILL_SMALL: return ELEM_W'($urandom_range(0, 511) - 256);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return CFG_W'($urandom_range(1, 4));
    if (r < 16) return CFG_W'($urandom_range(5, 8));
    if (r < 18) return CFG_W'($urandom_range(9, 15));
    return '0;
  endfunction

  function automatic int stim_total();
    int n;
    n = eff_dim(stim_dim[REG_INNER_SIZE]);
    return n * (eff_dim(stim_dim[REG_ROWS_OF_A]) + eff_dim(stim_dim[REG_COLS_OF_B]));
  endfunction

  task automatic push_matrices(input fill_t fill, input int count);
    for (int i = 0; i < count; i++) push_elem(rand_elem(fill));
  endtask

  function automatic int pick_gap();
    int r;
    if (gap_style == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(negedge clk) begin
    n_start = start && !elem_xfer;
    n_value = element_value;
    n_we    = 1'b0;
    n_index = cfg_index;
    n_data  = cfg_data;
    if (!rst && !n_start && pend_steps.size() > 0) begin
      case (pend_steps[0].kind)
        STEP_ELEM: begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            n_start  = 1'b1;
            n_value  = pend_steps[0].value;
            gap_left = pick_gap();
            void'(pend_steps.pop_front());
          end
        end
        STEP_CFG: begin
          n_we    = 1'b1;
          n_index = pend_steps[0].index;
          n_data  = pend_steps[0].value[CFG_W-1:0];
          void'(pend_steps.pop_front());
        end
        default: begin
          if (product_q.size() == 0 && !busy) begin
            if (settle_left > 0) begin
              settle_left--;
            end else begin
              settle_left = SETTLE_CYCLES;
              gap_style   = $urandom_range(0, 3);
              gap_left    = 0;
              void'(pend_steps.pop_front());
            end
          end else begin
            settle_left = SETTLE_CYCLES;
          end
        end
      endcase
    end
    start         <= n_start;
    element_value <= n_value;
    cfg_we        <= n_we;
    cfg_index     <= n_index;
    cfg_data      <= n_data;
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      elem_xfer    = 1'b0;
      quiet_cycles = 0;
      load_cnt     = 0;
      foreach (model_dim[i]) model_dim[i] = CFG_RESET;
    end else begin
      elem_xfer = start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_OF_A, REG_INNER_SIZE, REG_COLS_OF_B: begin
            model_dim[cfg_index] = cfg_data;
            load_cnt = 0;
          end
          default: ;
        endcase
      end
      if (elem_xfer) accept_element(element_value);
      if (result_strobe) begin
        if (product_q.size() == 0) begin
          report_mismatch("unexpected result, product", longint'(product_value), 0);
        end else begin
          want = product_q.pop_front();
          if (product_value !== want.product)
            report_mismatch("product_value", longint'(product_value), longint'(want.product));
          if (out_row !== want.row)
            report_mismatch("out_row", longint'(out_row), longint'(want.row));
          if (out_col !== want.col)
            report_mismatch("out_col", longint'(out_col), longint'(want.col));
          if (last_flag !== want.last)
            report_mismatch("last_flag", longint'(last_flag), longint'(want.last));
        end
      end
      if (elem_xfer || result_strobe || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int    total;
    int    cut;
    fill_t fill;
    foreach (stim_dim[i]) stim_dim[i] = CFG_RESET;
    stim_items = 0;

    // one row times one column at full depth, every operand most negative
    push_cfg(REG_ROWS_OF_A, 4'd1);
    push_cfg(REG_INNER_SIZE, 4'd8);
    push_cfg(REG_COLS_OF_B, 4'd1);
    for (int i = 0; i < 16; i++) push_elem(16'h8000);

    // zero dimension acts as one, oversized acts as the maximum
    push_drain();
    push_cfg(REG_INNER_SIZE, 4'd0);
    push_cfg(REG_COLS_OF_B, 4'd15);
    push_elem(16'h7fff);
    push_elem(16'h7fff);
    push_elem(16'h8000);
    push_elem(16'h0000);
    push_elem(16'hffff);
    push_elem(16'h0001);
    push_elem(16'h0100);
    push_elem(16'h7fff);
    push_elem(16'h8000);
    push_drain();
    push_cfg(REG_UNUSED, 4'd15);

    while (stim_items < ITEM_TARGET) begin
      push_drain();
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 2) != 0) push_cfg(CFG_IDX_W'(i), rand_dim());
      total = stim_total();
      // loading cut short by a register write
      if ($urandom_range(0, 6) == 0 && total > 1) begin
        cut = $urandom_range(1, total - 1);
        push_matrices(FILL_RANDOM, cut);
        push_drain();
        push_cfg(CFG_IDX_W'($urandom_range(0, 2)), rand_dim());
        total = stim_total();
      end
      for (int j = $urandom_range(1, 3); j > 0 && stim_items < ITEM_TARGET; j--) begin
        case ($urandom_range(0, 9))
          0: fill = FILL_EXTREME;
          1: fill = FILL_SMALL;
          default: fill = FILL_RANDOM;
        endcase
        push_matrices(fill, total);
      end
    end
    // last step waits for every result
    push_drain();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pend_steps.size() > 0 || start || product_q.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && product_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
